// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property, clocked on the rising edge, off while reset is low.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression that must be true at every rising edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  `ASSERT_PROP(lbl, clk, rst_n, (expr), msg)

`endif

// ===== rtl/core/pvio_pkg.sv =====
package pvio_pkg;

  // Item kind, carried on the input tuser
  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_TICK  = 2'd2
  } pvio_mode_e;

  // One item as held in the input register
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] offset;
    logic [7:0] wdata;
    logic [7:0] cols;
  } pvio_req_t;

  // Read response of one peripheral
  typedef struct packed {
    logic       hit;
    logic [7:0] rdata;
  } pvio_rsp_t;

  localparam int unsigned InTdataW  = 24;
  localparam int unsigned OutTdataW = 16;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned CfgDataW  = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_TIMER1_LATCH = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_TICK_PERIOD  = 8'd1;

  localparam logic [15:0] TICK_PERIOD_RST = 16'd20000;

  // PIA offsets
  localparam logic [7:0] OFF_PIA1_PA = 8'h10;
  localparam logic [7:0] OFF_PIA1_CA = 8'h11;
  localparam logic [7:0] OFF_PIA1_PB = 8'h12;
  localparam logic [7:0] OFF_PIA1_CB = 8'h13;
  localparam logic [7:0] OFF_PIA2_PA = 8'h20;
  localparam logic [7:0] OFF_PIA2_CA = 8'h21;
  localparam logic [7:0] OFF_PIA2_PB = 8'h22;
  localparam logic [7:0] OFF_PIA2_CB = 8'h23;

  // VIA offsets
  localparam logic [7:0] OFF_VIA_ORB  = 8'h40;
  localparam logic [7:0] OFF_VIA_ORA  = 8'h41;
  localparam logic [7:0] OFF_VIA_DDRB = 8'h42;
  localparam logic [7:0] OFF_VIA_DDRA = 8'h43;
  localparam logic [7:0] OFF_VIA_T1CH = 8'h45;
  localparam logic [7:0] OFF_VIA_PCR  = 8'h4C;
  localparam logic [7:0] OFF_VIA_IFR  = 8'h4D;
  localparam logic [7:0] OFF_VIA_IER  = 8'h4E;

  localparam logic [7:0] ROW_READ_FLAG = 8'h80;
  localparam logic [7:0] READ_MISS     = 8'hCD;

  localparam int unsigned PORT_CTRL_BIT = 2;  // PIA control: 1 port, 0 direction
  localparam int unsigned FRAME_BIT     = 5;  // VIA port B frame strobe
  localparam int unsigned IER_T1_BIT    = 6;
  localparam int unsigned IER_SET_BIT   = 7;

endpackage

// ===== rtl/core/pvio_pia.sv =====
module pvio_pia import pvio_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  pvio_req_t  req_i,
  output pvio_rsp_t  rsp_o,
  output logic [3:0] row_o
);

  // Only state that can reach a read or the row output is kept: port select
  // bits of the data registers that matter, PIA2 port latches, keyboard row.
  logic       pa1_sel_q, pa1_sel_d;
  logic       pa2_sel_q, pa2_sel_d;
  logic       pb2_sel_q, pb2_sel_d;
  logic [7:0] pa2_q, pa2_d;
  logic [7:0] pb2_q, pb2_d;
  logic [3:0] row_q, row_d;

  always_comb begin
    pa1_sel_d = pa1_sel_q;
    pa2_sel_d = pa2_sel_q;
    pb2_sel_d = pb2_sel_q;
    pa2_d     = pa2_q;
    pb2_d     = pb2_q;
    row_d     = row_q;
    rsp_o     = '0;
    if (req_i.mode == MODE_READ) begin
      unique case (req_i.offset)
        OFF_PIA1_PA: begin
          rsp_o.hit   = 1'b1;
          rsp_o.rdata = ROW_READ_FLAG | {4'b0000, row_q};
        end
        OFF_PIA1_CA: rsp_o.hit = 1'b1;
        OFF_PIA1_PB: begin
          rsp_o.hit   = 1'b1;
          rsp_o.rdata = req_i.cols;
        end
        OFF_PIA2_PA: begin
          rsp_o.hit   = 1'b1;
          rsp_o.rdata = pa2_q;
        end
        OFF_PIA2_PB: begin
          rsp_o.hit   = 1'b1;
          rsp_o.rdata = pb2_q;
        end
        default: ;
      endcase
    end else if (req_i.mode == MODE_WRITE) begin
      unique case (req_i.offset)
        OFF_PIA1_PA: begin
          rsp_o.hit = 1'b1;
          if (pa1_sel_q) begin
            row_d = req_i.wdata[3:0];
          end
        end
        OFF_PIA1_CA: begin
          rsp_o.hit = 1'b1;
          pa1_sel_d = req_i.wdata[PORT_CTRL_BIT];
        end
        OFF_PIA1_PB, OFF_PIA1_CB, OFF_PIA2_CB: rsp_o.hit = 1'b1;
        OFF_PIA2_PA: begin
          rsp_o.hit = 1'b1;
          if (pa2_sel_q) begin
            pa2_d = req_i.wdata;
          end
        end
        OFF_PIA2_CA: begin
          rsp_o.hit = 1'b1;
          pa2_sel_d = req_i.wdata[PORT_CTRL_BIT];
        end
        OFF_PIA2_PB: begin
          rsp_o.hit = 1'b1;
          if (pb2_sel_q) begin
            pb2_d = req_i.wdata;
          end
        end
        default: ;
      endcase
      // PIA2 B control write also has to land
      if (req_i.offset == OFF_PIA2_CB) begin
        pb2_sel_d = req_i.wdata[PORT_CTRL_BIT];
      end
    end
  end

  assign row_o = row_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pa1_sel_q <= 1'b0;
      pa2_sel_q <= 1'b0;
      pb2_sel_q <= 1'b0;
      pa2_q     <= '0;
      pb2_q     <= '0;
      row_q     <= '0;
    end else if (en_i) begin
      pa1_sel_q <= pa1_sel_d;
      pa2_sel_q <= pa2_sel_d;
      pb2_sel_q <= pb2_sel_d;
      pa2_q     <= pa2_d;
      pb2_q     <= pb2_d;
      row_q     <= row_d;
    end
  end

endmodule

// ===== rtl/core/pvio_via.sv =====
module pvio_via import pvio_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  pvio_req_t   req_i,
  input  logic [15:0] latch_i,
  input  logic [15:0] period_i,
  output pvio_rsp_t   rsp_o,
  output logic        irq_o
);

  // Port A, its direction, the flag register and the peripheral control have
  // no read path in this page, so only their address decode is kept.
  logic [7:0]  orb_q, orb_d;
  logic [7:0]  ddrb_q, ddrb_d;
  logic        ien_t1_q, ien_t1_d;
  logic [15:0] t1_q, t1_d;
  logic        t1_run_q, t1_run_d;
  logic [15:0] tick_q, tick_d;
  logic        irq_q, irq_d;

  always_comb begin
    orb_d    = orb_q;
    ddrb_d   = ddrb_q;
    ien_t1_d = ien_t1_q;
    t1_d     = t1_q;
    t1_run_d = t1_run_q;
    tick_d   = tick_q;
    irq_d    = irq_q;
    rsp_o    = '0;
    if (req_i.mode == MODE_READ) begin
      if (req_i.offset == OFF_VIA_ORB) begin
        rsp_o.hit   = 1'b1;
        rsp_o.rdata = orb_q;
      end
    end else if (req_i.mode == MODE_WRITE) begin
      unique case (req_i.offset)
        OFF_VIA_ORB: begin
          rsp_o.hit = 1'b1;
          orb_d     = req_i.wdata & ddrb_q;
        end
        OFF_VIA_DDRB: begin
          rsp_o.hit = 1'b1;
          ddrb_d    = req_i.wdata;
        end
        OFF_VIA_T1CH: begin
          rsp_o.hit = 1'b1;
          t1_d      = latch_i;
          t1_run_d  = 1'b1;
        end
        OFF_VIA_IER: begin
          rsp_o.hit = 1'b1;
          if (req_i.wdata[IER_SET_BIT]) begin
            ien_t1_d = ien_t1_q | req_i.wdata[IER_T1_BIT];
          end else begin
            ien_t1_d = ien_t1_q & ~req_i.wdata[IER_T1_BIT];
          end
        end
        OFF_VIA_ORA, OFF_VIA_DDRA, OFF_VIA_PCR, OFF_VIA_IFR: rsp_o.hit = 1'b1;
        default: ;
      endcase
    end else if (req_i.mode == MODE_TICK) begin
      // Frame counter: strobe port B bit and the line on the period match
      if (tick_q == period_i) begin
        tick_d           = '0;
        orb_d[FRAME_BIT] = 1'b1;
        irq_d            = 1'b1;
      end else begin
        tick_d           = tick_q + 16'd1;
        orb_d[FRAME_BIT] = 1'b0;
        irq_d            = 1'b0;
      end
      // One-shot timer 1 overrides the line while running
      if (t1_run_q) begin
        if (t1_q == '0) begin
          t1_run_d = 1'b0;
          irq_d    = ien_t1_q;
        end else begin
          t1_d  = t1_q - 16'd1;
          irq_d = 1'b0;
        end
      end
    end
  end

  assign irq_o = irq_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orb_q    <= '0;
      ddrb_q   <= '0;
      ien_t1_q <= 1'b0;
      t1_q     <= '0;
      t1_run_q <= 1'b0;
      tick_q   <= '0;
      irq_q    <= 1'b0;
    end else if (en_i) begin
      orb_q    <= orb_d;
      ddrb_q   <= ddrb_d;
      ien_t1_q <= ien_t1_d;
      t1_q     <= t1_d;
      t1_run_q <= t1_run_d;
      tick_q   <= tick_d;
      irq_q    <= irq_d;
    end
  end

endmodule

// ===== rtl/core/pia_via_io_block.sv =====
// I/O page with two PIAs and a VIA, one bus transaction or clock tick per item.
//
// Input stream: s_axis_tuser carries the kind (read, write, tick), s_axis_tdata
// the offset, write byte and keyboard column byte. Output stream: one
// transaction per item with read data, the interrupt line, the keyboard row
// and, on m_axis_tuser, the unhandled-offset flag.
// Configuration: cfg_valid_i/cfg_index_i/cfg_data_i, always ready; index 0 is
// the timer 1 latch, index 1 the frame tick period, other indexes are dropped.
// Write configuration only while no item is in flight.
//
// An item is captured in the input register and its result then in the result register.
// Throughput: one item per cycle while the receiver keeps up, set by the single stage
// of register update logic between the input register and the result register.
// When the receiver stalls, the result register holds and the input register
// keeps one further item; s_axis_tready drops only when both are full.
// Reset clears both stages, all peripheral state and the configuration
// (period back to 20000, latch to zero).
module pia_via_io_block import pvio_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,   // offset, write_data, key_columns
  input  logic [1:0]           s_axis_tuser,   // mode
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata,   // read_data, irq, keyboard_row, zero pad
  output logic                 m_axis_tuser,   // unhandled
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  logic                 in_valid_q;
  pvio_req_t            in_q;
  logic                 out_valid_q;
  logic [OutTdataW-1:0] out_data_q, out_data_d;
  logic                 out_user_q, out_user_d;
  logic [15:0]          latch_q;
  logic [15:0]          period_q;
  logic                 advance;
  pvio_rsp_t            pia_rsp;
  pvio_rsp_t            via_rsp;
  logic [3:0]           row;
  logic                 irq;
  logic                 is_rd;
  logic                 is_acc;
  logic                 hit;
  logic [7:0]           rdata;

  // Advance the held item once the result register is free or draining
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  pvio_pia u_pia (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .req_i  (in_q),
    .rsp_o  (pia_rsp),
    .row_o  (row)
  );

  pvio_via u_via (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .req_i    (in_q),
    .latch_i  (latch_q),
    .period_i (period_q),
    .rsp_o    (via_rsp),
    .irq_o    (irq)
  );

  // Merge the two peripherals; an unclaimed read returns the miss pattern
  assign is_rd  = in_q.mode == MODE_READ;
  assign is_acc = is_rd || (in_q.mode == MODE_WRITE);
  assign hit    = pia_rsp.hit || via_rsp.hit;

  always_comb begin
    rdata = '0;
    if (is_rd) begin
      rdata = hit ? (pia_rsp.rdata | via_rsp.rdata) : READ_MISS;
    end
    out_data_d = {3'b000, row, irq, rdata};
    out_user_d = is_acc && !hit;
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.mode   <= s_axis_tuser;
      in_q.offset <= s_axis_tdata[7:0];
      in_q.wdata  <= s_axis_tdata[15:8];
      in_q.cols   <= s_axis_tdata[23:16];
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q  <= '0;
      period_q <= TICK_PERIOD_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_TIMER1_LATCH) begin
        latch_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_TICK_PERIOD) begin
        period_q <= cfg_data_i;
      end
    end
  end

endmodule

// ===== rtl/core/pvio_checker.sv =====
`include "assert_macros.svh"

module pvio_checker import pvio_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OutTdataW-1:0] m_axis_tdata,
  input logic                 m_axis_tuser
);

  logic out_stall;
  logic in_take;
  logic miss_ok;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign in_take   = s_axis_tvalid && s_axis_tready;
  assign miss_ok   = (m_axis_tdata[7:0] == READ_MISS) || (m_axis_tdata[7:0] == 8'h00);

  `ASSERT_PROP(a_out_hold, clk_i, rst_ni,
    out_stall |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  `ASSERT_ALWAYS(a_no_backpressure, clk_i, rst_ni,
    !m_axis_tready || s_axis_tready, "input stalled while output drains")

  `ASSERT_PROP(a_latency, clk_i, rst_ni,
    in_take ##1 m_axis_tready |=> m_axis_tvalid, "result missing two cycles after input")

  `ASSERT_ALWAYS(a_miss_data, clk_i, rst_ni,
    !(m_axis_tvalid && m_axis_tuser) || miss_ok, "unhandled access with unexpected read data")

  `ASSERT_ALWAYS(a_pad_zero, clk_i, rst_ni,
    !m_axis_tvalid || m_axis_tdata[15:13] == 3'b000, "output pad bits set")

endmodule

bind pia_via_io_block pvio_checker u_pvio_checker (.*);

// ===== bench/tb_pia_via_io_block.sv =====
`timescale 1ns / 100ps

module tb_pia_via_io_block;
  import pvio_pkg::*;

  // Codes the package leaves unnamed
  localparam logic [1:0]         MODE_IGNORED   = 2'd3;   // fourth kind, ignored by the peripherals
  localparam logic [CfgIdxW-1:0] CFG_UNUSED_IDX = 8'hFF;  // no register behind it
  localparam logic [7:0]         FLAG_CB_MASK   = 8'h18;  // CB1/CB2 interrupt flags
  localparam logic [7:0]         FLAG_CA_MASK   = 8'h03;  // CA1/CA2 interrupt flags
  localparam logic [7:0]         FLAG_T1        = 8'h40;  // timer 1 interrupt flag
  localparam logic [7:0]         IER_VALUE_MASK = 8'h7F;  // enable bits below the set/clear bit
  localparam int unsigned        HOLD_CYCLES    = 300;

  // One result as it should leave the block
  typedef struct packed {
    logic [7:0] rdata;
    logic       irq;
    logic [3:0] row;
    logic       unhandled;
  } io_result_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;  // offset [7:0], write_data [15:8], key_columns [23:16]
  logic [1:0]           s_axis_tuser  = '0;  // mode
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;        // read_data [7:0], irq [8], keyboard_row [12:9], pad
  logic                 m_axis_tuser;        // unhandled
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i  = '0;

  pia_via_io_block uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Items waiting to be offered, and results owed by the block, oldest first
  pvio_req_t  bus_items[$];
  io_result_t io_results_due[$];

  int unsigned sender_idle_pct = 0;
  int unsigned rx_stall_pct    = 0;
  logic        hold_request    = 1'b0;
  logic        rx_hold         = 1'b0;
  int unsigned error_count     = 0;

  // ---------------------------------------------------------------------------
  // Shadow copy of the I/O page: configuration plus peripheral state
  // ---------------------------------------------------------------------------
  logic [15:0] t1_latch     = '0;
  logic [15:0] frame_period = TICK_PERIOD_RST;

  logic [7:0]  pia_ctrl   [4] = '{default: '0};
  logic [7:0]  pia_port_q [4] = '{default: '0};
  logic [7:0]  pia_ddr    [4] = '{default: '0};
  logic [7:0]  via_ora  = '0;
  logic [7:0]  via_orb  = '0;
  logic [7:0]  via_ddra = '0;
  logic [7:0]  via_ddrb = '0;
  logic [7:0]  via_pcr  = '0;
  logic [7:0]  via_ifr  = '0;
  logic [7:0]  via_ier  = '0;
  logic [15:0] t1_count    = '0;
  logic        t1_run      = 1'b0;
  logic [15:0] frame_count = '0;
  logic [3:0]  kb_row      = '0;
  logic        irq_q       = 1'b0;

  // Control bit 2 steers a data write to the port, else to the direction register
  function automatic void pia_store(int unsigned idx, logic [7:0] d);
    if (pia_ctrl[idx][PORT_CTRL_BIT]) pia_port_q[idx] = d;
    else pia_ddr[idx] = d;
  endfunction

  // Advance the shadow page by one item and return the result it owes
  function automatic io_result_t io_page_step(pvio_req_t req);
    io_result_t res;
    logic [7:0] d;
    res = '0;
    d   = req.wdata;
    case (req.mode)
      MODE_READ: begin
        case (req.offset)
          OFF_PIA1_PA: res.rdata = ROW_READ_FLAG | {4'b0000, kb_row};
          OFF_PIA1_CA: res.rdata = '0;
          OFF_PIA1_PB: res.rdata = req.cols;
          OFF_PIA2_PA: res.rdata = pia_port_q[2];
          OFF_PIA2_PB: res.rdata = pia_port_q[3];
          OFF_VIA_ORB: begin
            via_ifr   = via_ifr & ~FLAG_CB_MASK;
            res.rdata = via_orb;
          end
          default: begin
            res.rdata     = READ_MISS;
            res.unhandled = 1'b1;
          end
        endcase
      end
      MODE_WRITE: begin
        case (req.offset)
          OFF_PIA1_PA: begin
            if (pia_ctrl[0][PORT_CTRL_BIT]) begin
              pia_port_q[0] = d;
              kb_row        = d[3:0];
            end else begin
              pia_ddr[0] = d;
            end
          end
          OFF_PIA1_CA: pia_ctrl[0] = d;
          OFF_PIA1_PB: pia_store(1, d);
          OFF_PIA1_CB: pia_ctrl[1] = d;
          OFF_PIA2_PA: pia_store(2, d);
          OFF_PIA2_CA: pia_ctrl[2] = d;
          OFF_PIA2_PB: pia_store(3, d);
          OFF_PIA2_CB: pia_ctrl[3] = d;
          OFF_VIA_ORB: begin
            via_orb = d & via_ddrb;
            via_ifr = via_ifr & ~FLAG_CB_MASK;
          end
          OFF_VIA_ORA: begin
            via_ora = d & via_ddra;
            via_ifr = via_ifr & ~FLAG_CA_MASK;
          end
          OFF_VIA_DDRB: via_ddrb = d;
          OFF_VIA_DDRA: via_ddra = d;
          OFF_VIA_T1CH: begin
            t1_count = t1_latch;
            via_ifr  = via_ifr & ~FLAG_T1;
            t1_run   = 1'b1;
          end
          OFF_VIA_PCR: via_pcr = d;
          OFF_VIA_IFR: via_ifr = via_ifr & ~d;
          OFF_VIA_IER: begin
            if (d[IER_SET_BIT]) via_ier = via_ier | (d & IER_VALUE_MASK);
            else via_ier = via_ier & ~(d & IER_VALUE_MASK);
          end
          default: res.unhandled = 1'b1;
        endcase
      end
      MODE_TICK: begin
        // Frame strobe first, then timer 1 may override the interrupt line
        if (frame_count == frame_period) begin
          frame_count       = '0;
          via_orb[FRAME_BIT] = 1'b1;
          irq_q             = 1'b1;
        end else begin
          frame_count       = frame_count + 16'd1;
          via_orb[FRAME_BIT] = 1'b0;
          irq_q             = 1'b0;
        end
        if (t1_run) begin
          if (t1_count == '0) begin
            // Underflow: one-shot stops and flags; only enable bit 6 drives the line
            t1_run  = 1'b0;
            via_ifr = via_ifr | FLAG_T1;
            irq_q   = via_ier[IER_T1_BIT];
          end else begin
            t1_count = t1_count - 16'd1;
            irq_q    = 1'b0;
          end
        end
      end
      default: ;
    endcase
    res.irq = irq_q;
    res.row = kb_row;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_item(logic [1:0] mode, logic [7:0] off, logic [7:0] wd,
                                     logic [7:0] cols);
    pvio_req_t req;
    req.mode   = mode;
    req.offset = off;
    req.wdata  = wd;
    req.cols   = cols;
    bus_items.push_back(req);
  endfunction

  function automatic logic [7:0] mapped_offset(int unsigned k);
    case (k)
      0:  return OFF_PIA1_PA;
      1:  return OFF_PIA1_CA;
      2:  return OFF_PIA1_PB;
      3:  return OFF_PIA1_CB;
      4:  return OFF_PIA2_PA;
      5:  return OFF_PIA2_CA;
      6:  return OFF_PIA2_PB;
      7:  return OFF_PIA2_CB;
      8:  return OFF_VIA_ORB;
      9:  return OFF_VIA_ORA;
      10: return OFF_VIA_DDRB;
      11: return OFF_VIA_DDRA;
      12: return OFF_VIA_T1CH;
      13: return OFF_VIA_PCR;
      14: return OFF_VIA_IFR;
      default: return OFF_VIA_IER;
    endcase
  endfunction

  // Mostly mapped offsets so the peripherals get exercised; a share of raw noise
  function automatic void queue_random_items(int unsigned count);
    int unsigned pick;
    logic [1:0]  mode;
    logic [7:0]  off;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 30) mode = MODE_READ;
      else if (pick < 65) mode = MODE_WRITE;
      else if (pick < 95) mode = MODE_TICK;
      else mode = MODE_IGNORED;
      if ($urandom_range(99) < 85) off = mapped_offset($urandom_range(15));
      else off = 8'($urandom_range(255));
      queue_item(mode, off, 8'($urandom_range(255)), 8'($urandom_range(255)));
    end
  endfunction

  // Write one register at an idle point and mirror it in the shadow
  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_TIMER1_LATCH) t1_latch = val;
    else if (idx == CFG_TICK_PERIOD) frame_period = val;
  endtask

  // Hold until every item is in and every result is out, then let the pipe settle
  task automatic wait_drained();
    @(negedge clk_i);
    while (bus_items.size() != 0 || s_axis_tvalid || io_results_due.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic compare_field(string name, logic [7:0] exp, logic [7:0] act);
    if (exp !== act) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Driver: offer queued items, predict each one at its accepting edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : feed_items
    pvio_req_t taken;
    pvio_req_t next_req;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        taken.mode   = s_axis_tuser;
        taken.offset = s_axis_tdata[7:0];
        taken.wdata  = s_axis_tdata[15:8];
        taken.cols   = s_axis_tdata[23:16];
        io_results_due.push_back(io_page_step(taken));
      end
      // Only move on once the current offer is taken; hold it otherwise
      if (!s_axis_tvalid || s_axis_tready) begin
        if (bus_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_req = bus_items.pop_front();
          s_axis_tuser  <= next_req.mode;
          s_axis_tdata  <= {next_req.cols, next_req.wdata, next_req.offset};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check every result transaction against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    io_result_t due;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (io_results_due.size() == 0) begin
          error_count++;
          $display("%0t: result with nothing expected, expected none, actual %h/%b",
                   $time, m_axis_tdata, m_axis_tuser);
        end else begin
          due = io_results_due.pop_front();
          compare_field("read_data", due.rdata, m_axis_tdata[7:0]);
          compare_field("irq", {7'b0, due.irq}, {7'b0, m_axis_tdata[8]});
          compare_field("keyboard_row", {4'b0, due.row}, {4'b0, m_axis_tdata[12:9]});
          compare_field("pad", 8'h00, {5'b0, m_axis_tdata[15:13]});
          compare_field("unhandled", {7'b0, due.unhandled}, {7'b0, m_axis_tuser});
        end
      end
      m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Long receiver hold-off, counted here, so the block backs up onto its input
  initial begin : receiver_hold_off
    wait (hold_request);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sequence of phases
  // ---------------------------------------------------------------------------
  initial begin : run_phases
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Period zero while the frame counter is still zero: every tick strobes
    write_register(CFG_TIMER1_LATCH, 16'h0000);
    write_register(CFG_TICK_PERIOD, 16'h0000);

    // Directed: row select, port versus direction, key columns, VIA ports,
    // timer expiry with and without enable bit 6, flag clear, misses, ignored kind
    queue_item(MODE_READ,  OFF_PIA1_PA,  8'h00, 8'h00);
    queue_item(MODE_WRITE, OFF_PIA1_CA,  8'h04, 8'h00);
    queue_item(MODE_WRITE, OFF_PIA1_PA,  8'hFF, 8'h00);
    queue_item(MODE_READ,  OFF_PIA1_PA,  8'h00, 8'h00);
    queue_item(MODE_WRITE, OFF_PIA1_CA,  8'h00, 8'h00);
    queue_item(MODE_WRITE, OFF_PIA1_PA,  8'h5A, 8'h00);
    queue_item(MODE_READ,  OFF_PIA1_PB,  8'h00, 8'hFF);
    queue_item(MODE_READ,  OFF_PIA1_CA,  8'h00, 8'h00);
    queue_item(MODE_WRITE, OFF_PIA2_CA,  8'h04, 8'h00);
    queue_item(MODE_WRITE, OFF_PIA2_PA,  8'hFF, 8'h00);
    queue_item(MODE_READ,  OFF_PIA2_PA,  8'h00, 8'h00);
    queue_item(MODE_WRITE, OFF_PIA2_PB,  8'h3C, 8'h00);
    queue_item(MODE_READ,  OFF_PIA2_PB,  8'h00, 8'h00);
    queue_item(MODE_WRITE, OFF_VIA_DDRB, 8'hFF, 8'h00);
    queue_item(MODE_WRITE, OFF_VIA_ORB,  8'hFF, 8'h00);
    queue_item(MODE_READ,  OFF_VIA_ORB,  8'h00, 8'h00);
    queue_item(MODE_WRITE, OFF_VIA_IER,  8'hC0, 8'h00);
    queue_item(MODE_WRITE, OFF_VIA_T1CH, 8'h00, 8'h00);
    queue_item(MODE_TICK,  8'h00,        8'h00, 8'h00);
    queue_item(MODE_WRITE, OFF_VIA_IER,  8'h40, 8'h00);
    queue_item(MODE_WRITE, OFF_VIA_T1CH, 8'h00, 8'h00);
    queue_item(MODE_TICK,  8'h00,        8'h00, 8'h00);
    queue_item(MODE_WRITE, OFF_VIA_IFR,  8'hFF, 8'h00);
    queue_item(MODE_READ,  8'hFF,        8'h00, 8'h00);
    queue_item(MODE_WRITE, 8'h00,        8'hFF, 8'h00);
    queue_item(MODE_IGNORED, OFF_PIA1_PA, 8'hFF, 8'hFF);
    wait_drained();

    // No idling on either side; also drop a write to an index with no register
    write_register(CFG_TIMER1_LATCH, 16'd7);
    write_register(CFG_TICK_PERIOD, 16'd12);
    write_register(CFG_UNUSED_IDX, 16'hFFFF);
    queue_random_items(400);
    wait_drained();

    // Sender idle most of the time
    write_register(CFG_TIMER1_LATCH, 16'hFFFF);
    write_register(CFG_TICK_PERIOD, 16'd30);
    sender_idle_pct = 71;
    queue_random_items(400);
    wait_drained();

    // Receiver stalling most of the time
    write_register(CFG_TIMER1_LATCH, 16'd3);
    write_register(CFG_TICK_PERIOD, 16'd45);
    sender_idle_pct = 0;
    rx_stall_pct    = 71;
    queue_random_items(400);
    wait_drained();

    // Both sides idling now and then
    write_register(CFG_TIMER1_LATCH, 16'd20);
    write_register(CFG_TICK_PERIOD, 16'hFFFF);
    sender_idle_pct = 16;
    rx_stall_pct    = 16;
    queue_random_items(400);
    wait_drained();

    // Back-pressure: sender flat out while the receiver holds off
    sender_idle_pct = 0;
    rx_stall_pct    = 0;
    hold_request    = 1'b1;
    queue_random_items(80);
    wait_drained();

    repeat (10) @(negedge clk_i);
    if (io_results_due.size() != 0) begin
      error_count++;
      $display("%0t: results still owed, expected 0, actual %0d", $time,
               io_results_due.size());
    end
    if (error_count == 0) begin
      $display("tb_pia_via_io_block: done, clean");
    end else begin
      $display("tb_pia_via_io_block: done, errors");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("tb_pia_via_io_block: done, errors");
    $finish;
  end

endmodule
